### design/lshs_pkg.sv
// shared types, constants and codes for the lattice site hash set
package lshs_pkg;

    localparam int TABLE_SIZE = 1024;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int MAX_OWNERS = 512;
    localparam int OWNER_W    = $clog2(MAX_OWNERS);
    localparam int COORD_W    = 16;
    localparam int KEY_W      = 3 * COORD_W;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_e_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Z = 2'd2;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [OWNER_W-1:0]        monomer;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [OWNER_W-1:0] owner;
        logic [SLOT_W-1:0]  slot;
        logic [1:0]         status;
    } rsp_t;

    // key packed as z, y, x from the top
    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key;
        logic [OWNER_W-1:0] owner;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic                      go;
        logic [KEY_W-1:0]          key;
        logic signed [COORD_W-1:0] coef_x;
        logic signed [COORD_W-1:0] coef_y;
        logic signed [COORD_W-1:0] coef_z;
    } hash_req_t;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] home;
    } hash_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_HASH,
        S_PRD,
        S_PCHK,
        S_INS,
        S_RSOM,
        S_RA,
        S_RACHK,
        S_NRD,
        S_NCHK,
        S_REWR,
        S_DONE
    } state_t;

endpackage

### design/lshs_ram.sv
// generic single write port memory with registered read
module lshs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/lshs_hash.sv
// home slot unit: one multiply-accumulate per cycle over x, y, z
module lshs_hash (
    input  logic                clk,
    input  logic                rst_n,
    input  lshs_pkg::hash_req_t req,
    output lshs_pkg::hash_rsp_t rsp
);

    logic [lshs_pkg::KEY_W-1:0]         key_reg;
    logic [1:0]                         cnt_reg;
    logic                               run_reg;
    logic                               done_reg;
    logic signed [lshs_pkg::ACC_W-1:0]  acc_reg;
    logic signed [lshs_pkg::COORD_W-1:0] mul_a;
    logic signed [lshs_pkg::COORD_W-1:0] mul_b;
    logic signed [lshs_pkg::PROD_W-1:0]  prod;
    logic [lshs_pkg::SLOT_W-1:0]         low;

    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                mul_a = req.coef_x;
                mul_b = key_reg[lshs_pkg::COORD_W-1:0];
            end
            2'd1:
            begin
                mul_a = req.coef_y;
                mul_b = key_reg[2*lshs_pkg::COORD_W-1:lshs_pkg::COORD_W];
            end
            default:
            begin
                mul_a = req.coef_z;
                mul_b = key_reg[lshs_pkg::KEY_W-1:2*lshs_pkg::COORD_W];
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            key_reg <= req.key;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_reg + lshs_pkg::ACC_W'(prod);
        end
    end

    // |s| mod table size only needs the low bits and the sign
    assign low      = acc_reg[lshs_pkg::SLOT_W-1:0];
    assign rsp.done = done_reg;
    assign rsp.home = acc_reg[lshs_pkg::ACC_W-1] ? (~low + 1'b1) : low;

endmodule

### design/lattice_site_hash_set.sv
// top level of the lattice site hash set: command sequencer and slot memories
//
// usage:
//   a command transfer happens at a clock edge with start high and busy low;
//   req carries command, site coordinates and owner index
//   the result appears on rsp for exactly one cycle with done high and must
//   be taken then; the receiver cannot stall it
//   coefficients are written through cfg_we / cfg_index / cfg_data while idle
// steps per command (an entry read takes a read state and a check state):
//   lookup / insert: hash, then a read and a check per probed slot, then the
//     result, with a write step before it for a stored insert
//   remove: find and free the owner's slot, then per entry of the
//     following run read it, hash it, probe, write it to its new slot, and
//     finally read the empty slot that ends the run and give the result
//   clear: one slot per cycle over the whole table, then the result
//   all of it is bound by the single read port of the slot memory
// reset:
//   after rst_n rises the block sweeps the whole slot memory with busy high,
//   before taking the first command; coefficients reset to 1
module lattice_site_hash_set (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  lshs_pkg::req_t                   req,
    output logic                             done,
    output lshs_pkg::rsp_t                   rsp,
    input  logic                             cfg_we,
    input  logic [lshs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lshs_pkg::COORD_W-1:0]     cfg_data
);

    // sequencer state
    lshs_pkg::state_t state_reg, state_next;
    logic             boot_reg, boot_next;

    // hash coefficients
    logic signed [lshs_pkg::COORD_W-1:0] coef_x_reg, coef_y_reg, coef_z_reg;

    // latched command and work registers
    lshs_pkg::cmd_e_t              op_reg, op_next;
    logic [lshs_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [lshs_pkg::OWNER_W-1:0]  mono_reg, mono_next;
    logic [lshs_pkg::OWNER_W-1:0]  own_reg, own_next;
    logic [lshs_pkg::SLOT_W-1:0]   pos_reg, pos_next;
    logic [lshs_pkg::SLOT_W-1:0]   home_reg, home_next;
    logic [lshs_pkg::CNT_W-1:0]    pcnt_reg, pcnt_next;
    logic [lshs_pkg::SLOT_W-1:0]   base_reg, base_next;
    logic [lshs_pkg::CNT_W-1:0]    ncnt_reg, ncnt_next;
    logic [lshs_pkg::SLOT_W-1:0]   clr_reg, clr_next;
    lshs_pkg::rsp_t                rsp_reg, rsp_next;

    // slot memory ports
    logic                          ent_we;
    logic [lshs_pkg::SLOT_W-1:0]   ent_waddr, ent_raddr;
    lshs_pkg::entry_t              ent_wdata, ent_q;
    logic [lshs_pkg::ENTRY_W-1:0]  ent_rdata;

    // owner-to-slot memory ports
    logic                          som_we;
    logic [lshs_pkg::OWNER_W-1:0]  som_waddr, som_raddr;
    logic [lshs_pkg::SLOT_W-1:0]   som_wdata, som_q;

    lshs_pkg::hash_req_t hreq;
    lshs_pkg::hash_rsp_t hrsp;

    // probe decode on the entry just read
    logic                          p_empty, p_match, p_last, run_end;
    logic [lshs_pkg::SLOT_W-1:0]   idx;
    logic [lshs_pkg::KEY_W-1:0]    req_key;

    assign ent_q   = lshs_pkg::entry_t'(ent_rdata);
    assign p_empty = !ent_q.used;
    assign p_match = ent_q.used && (ent_q.key == key_reg);
    assign p_last  = (pcnt_reg == lshs_pkg::CNT_W'(lshs_pkg::TABLE_SIZE - 1));
    assign run_end = (ncnt_reg == lshs_pkg::CNT_W'(lshs_pkg::TABLE_SIZE));
    assign idx     = base_reg + ncnt_reg[lshs_pkg::SLOT_W-1:0];
    assign req_key = {req.coord_z, req.coord_y, req.coord_x};

    lshs_ram #(
        .WIDTH (lshs_pkg::ENTRY_W),
        .DEPTH (lshs_pkg::TABLE_SIZE)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    lshs_ram #(
        .WIDTH (lshs_pkg::SLOT_W),
        .DEPTH (lshs_pkg::MAX_OWNERS)
    ) u_owner_ram (
        .clk   (clk),
        .we    (som_we),
        .waddr (som_waddr),
        .wdata (som_wdata),
        .raddr (som_raddr),
        .rdata (som_q)
    );

    lshs_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .rsp   (hrsp)
    );

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg <= lshs_pkg::COORD_W'(1);
            coef_y_reg <= lshs_pkg::COORD_W'(1);
            coef_z_reg <= lshs_pkg::COORD_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lshs_pkg::CFG_COEF_X: coef_x_reg <= cfg_data;
                lshs_pkg::CFG_COEF_Y: coef_y_reg <= cfg_data;
                lshs_pkg::CFG_COEF_Z: coef_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lshs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (lshs_pkg::cmd_e_t'(req.command))
                        lshs_pkg::CMD_LOOKUP, lshs_pkg::CMD_INSERT:
                            state_next = lshs_pkg::S_HASH;
                        lshs_pkg::CMD_REMOVE: state_next = lshs_pkg::S_RSOM;
                        default:              state_next = lshs_pkg::S_CLR;
                    endcase
                end
            end
            lshs_pkg::S_CLR:
            begin
                if (&clr_reg)
                begin
                    state_next = boot_reg ? lshs_pkg::S_IDLE : lshs_pkg::S_DONE;
                end
            end
            lshs_pkg::S_HASH:
            begin
                if (hrsp.done)
                begin
                    state_next = lshs_pkg::S_PRD;
                end
            end
            lshs_pkg::S_PRD: state_next = lshs_pkg::S_PCHK;
            lshs_pkg::S_PCHK:
            begin
                if (!p_empty && !p_match && !p_last)
                begin
                    state_next = lshs_pkg::S_PRD;
                end
                else if (op_reg == lshs_pkg::CMD_REMOVE)
                begin
                    if (p_empty)
                        state_next = lshs_pkg::S_REWR;
                    else
                        state_next = run_end ? lshs_pkg::S_DONE : lshs_pkg::S_NRD;
                end
                else if (p_empty && op_reg == lshs_pkg::CMD_INSERT)
                begin
                    state_next = lshs_pkg::S_INS;
                end
                else
                begin
                    state_next = lshs_pkg::S_DONE;
                end
            end
            lshs_pkg::S_INS:  state_next = lshs_pkg::S_DONE;
            lshs_pkg::S_RSOM: state_next = lshs_pkg::S_RA;
            lshs_pkg::S_RA:   state_next = lshs_pkg::S_RACHK;
            lshs_pkg::S_RACHK:
                state_next = p_empty ? lshs_pkg::S_DONE : lshs_pkg::S_NRD;
            lshs_pkg::S_NRD:  state_next = lshs_pkg::S_NCHK;
            lshs_pkg::S_NCHK:
                state_next = p_empty ? lshs_pkg::S_DONE : lshs_pkg::S_HASH;
            lshs_pkg::S_REWR:
                state_next = run_end ? lshs_pkg::S_DONE : lshs_pkg::S_NRD;
            lshs_pkg::S_DONE: state_next = lshs_pkg::S_IDLE;
            default:          state_next = lshs_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        boot_next = boot_reg;
        op_next   = op_reg;
        key_next  = key_reg;
        mono_next = mono_reg;
        own_next  = own_reg;
        pos_next  = pos_reg;
        home_next = home_reg;
        pcnt_next = pcnt_reg;
        base_next = base_reg;
        ncnt_next = ncnt_reg;
        clr_next  = clr_reg;
        rsp_next  = rsp_reg;

        ent_we    = 1'b0;
        ent_waddr = pos_reg;
        ent_wdata = '{used: 1'b1, key: key_reg, owner: mono_reg};
        ent_raddr = pos_reg;
        som_we    = 1'b0;
        som_waddr = mono_reg;
        som_wdata = pos_reg;
        som_raddr = mono_reg;

        hreq.go     = 1'b0;
        hreq.key    = req_key;
        hreq.coef_x = coef_x_reg;
        hreq.coef_y = coef_y_reg;
        hreq.coef_z = coef_z_reg;

        unique case (state_reg)
            lshs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next   = lshs_pkg::cmd_e_t'(req.command);
                    key_next  = req_key;
                    mono_next = req.monomer;
                    clr_next  = '0;
                    rsp_next  = '0;
                    hreq.go   = (req.command == lshs_pkg::CMD_LOOKUP)
                             || (req.command == lshs_pkg::CMD_INSERT);
                end
            end
            lshs_pkg::S_CLR:
            begin
                ent_we    = 1'b1;
                ent_waddr = clr_reg;
                ent_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    boot_next = 1'b0;
                end
            end
            lshs_pkg::S_HASH:
            begin
                if (hrsp.done)
                begin
                    pos_next  = hrsp.home;
                    home_next = hrsp.home;
                    pcnt_next = '0;
                end
            end
            lshs_pkg::S_PRD: ent_raddr = pos_reg;
            lshs_pkg::S_PCHK:
            begin
                if (!p_empty && !p_match && !p_last)
                begin
                    pos_next  = pos_reg + 1'b1;
                    pcnt_next = pcnt_reg + 1'b1;
                end
                else if (op_reg == lshs_pkg::CMD_REMOVE)
                begin
                    if (!p_empty && !run_end)
                    begin
                        ncnt_next = ncnt_reg + 1'b1;
                    end
                end
                else if (p_empty)
                begin
                    rsp_next.slot = pos_reg;
                end
                else if (p_match)
                begin
                    rsp_next.hit   = 1'b1;
                    rsp_next.owner = ent_q.owner;
                    rsp_next.slot  = pos_reg;
                end
                else
                begin
                    rsp_next.slot = home_reg;
                    if (op_reg == lshs_pkg::CMD_INSERT)
                    begin
                        rsp_next.status = lshs_pkg::ST_FULL;
                    end
                end
            end
            lshs_pkg::S_INS:
            begin
                ent_we = 1'b1;
                som_we = 1'b1;
            end
            lshs_pkg::S_RSOM: som_raddr = mono_reg;
            lshs_pkg::S_RA:
            begin
                base_next = som_q;
                ent_raddr = som_q;
            end
            lshs_pkg::S_RACHK:
            begin
                rsp_next.slot = base_reg;
                if (p_empty)
                begin
                    rsp_next.status = lshs_pkg::ST_EMPTY;
                end
                else
                begin
                    ent_we    = 1'b1;
                    ent_waddr = base_reg;
                    ent_wdata = '{used: 1'b0, key: ent_q.key, owner: ent_q.owner};
                    ncnt_next = lshs_pkg::CNT_W'(1);
                end
            end
            lshs_pkg::S_NRD: ent_raddr = idx;
            lshs_pkg::S_NCHK:
            begin
                if (!p_empty)
                begin
                    // take the entry out of the run and hash it again
                    ent_we    = 1'b1;
                    ent_waddr = idx;
                    ent_wdata = '{used: 1'b0, key: ent_q.key, owner: ent_q.owner};
                    key_next  = ent_q.key;
                    own_next  = ent_q.owner;
                    hreq.go   = 1'b1;
                    hreq.key  = ent_q.key;
                end
            end
            lshs_pkg::S_REWR:
            begin
                ent_we    = 1'b1;
                ent_wdata = '{used: 1'b1, key: key_reg, owner: own_reg};
                som_we    = 1'b1;
                som_waddr = own_reg;
                if (!run_end)
                begin
                    ncnt_next = ncnt_reg + 1'b1;
                end
            end
            lshs_pkg::S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lshs_pkg::S_CLR;
            boot_reg  <= 1'b1;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            boot_reg  <= boot_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        mono_reg <= mono_next;
        own_reg  <= own_next;
        pos_reg  <= pos_next;
        home_reg <= home_next;
        pcnt_reg <= pcnt_next;
        base_reg <= base_next;
        ncnt_reg <= ncnt_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != lshs_pkg::S_IDLE);
    assign done = (state_reg == lshs_pkg::S_DONE);
    assign rsp  = rsp_reg;

endmodule

### design/lshs_checker.sv
// port-level checks for the lattice site hash set, bound to the top level
module lshs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input lshs_pkg::rsp_t rsp
);

    // a result transfer ends the command
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy still high after result transfer");

    // an accepted command keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // results only leave a busy block
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result transfer while idle");

    // status is always a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == lshs_pkg::ST_OK || rsp.status == lshs_pkg::ST_FULL
                  || rsp.status == lshs_pkg::ST_EMPTY))
        else $error("undefined status code");

    // a hit never comes with an error
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.hit) |-> (rsp.status == lshs_pkg::ST_OK))
        else $error("hit reported with error status");

endmodule

bind lattice_site_hash_set lshs_checker u_lshs_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

### tb/sv/tb_lattice_site_hash_set.sv
// testbench for the lattice site hash set: random and directed commands checked by a scoreboard

class site_set_scoreboard;
    // shadow state of the hash set
    bit                                 used [lshs_pkg::TABLE_SIZE];
    bit [lshs_pkg::KEY_W-1:0]           keys [lshs_pkg::TABLE_SIZE];
    bit [lshs_pkg::OWNER_W-1:0]         owners [lshs_pkg::TABLE_SIZE];
    bit [lshs_pkg::SLOT_W-1:0]          slot_of [lshs_pkg::MAX_OWNERS];
    bit                                 recorded [lshs_pkg::MAX_OWNERS];
    int                                 coef_x = 1;
    int                                 coef_y = 1;
    int                                 coef_z = 1;
    lshs_pkg::rsp_t                     pending_rsp[$];
    int                                 mismatches = 0;
    int                                 orphans = 0;

    function int unsigned home_of(bit [lshs_pkg::KEY_W-1:0] k);
        longint s;
        s = longint'(coef_x) * longint'($signed(k[15:0]))
          + longint'(coef_y) * longint'($signed(k[31:16]))
          + longint'(coef_z) * longint'($signed(k[47:32]));
        if (s < 0)
            s = -s;
        return int'(s % lshs_pkg::TABLE_SIZE);
    endfunction

    // 0 empty met, 1 match, 2 table full
    function int probe(bit [lshs_pkg::KEY_W-1:0] k, output int unsigned where);
        int unsigned h;
        int unsigned s;
        h = home_of(k);
        for (int n = 0; n < lshs_pkg::TABLE_SIZE; n++)
        begin
            s = (h + n) % lshs_pkg::TABLE_SIZE;
            if (!used[s])
            begin
                where = s;
                return 0;
            end
            if (keys[s] == k)
            begin
                where = s;
                return 1;
            end
        end
        where = h;
        return 2;
    endfunction

    function void place(int unsigned s, bit [lshs_pkg::KEY_W-1:0] k,
                        bit [lshs_pkg::OWNER_W-1:0] o);
        used[s]     = 1;
        keys[s]     = k;
        owners[s]   = o;
        slot_of[o]  = lshs_pkg::SLOT_W'(s);
        recorded[o] = 1;
    endfunction

    function void set_coef(int idx, bit [15:0] v);
        if (idx == lshs_pkg::CFG_COEF_X)
            coef_x = $signed(v);
        else if (idx == lshs_pkg::CFG_COEF_Y)
            coef_y = $signed(v);
        else
            coef_z = $signed(v);
    endfunction

    // note an accepted command and queue its predicted result
    function void note_command(lshs_pkg::req_t r);
        lshs_pkg::rsp_t           p;
        bit [lshs_pkg::KEY_W-1:0] k;
        int unsigned              s;
        int unsigned              a;
        int unsigned              i;
        int unsigned              t;
        int                       res;
        p = '0;
        k = {r.coord_z, r.coord_y, r.coord_x};
        case (r.command)
            lshs_pkg::CMD_LOOKUP, lshs_pkg::CMD_INSERT:
            begin
                res = probe(k, s);
                p.slot = lshs_pkg::SLOT_W'(s);
                if (res == 1)
                begin
                    p.hit   = 1;
                    p.owner = owners[s];
                end
                else if (r.command == lshs_pkg::CMD_INSERT)
                begin
                    if (res == 0)
                        place(s, k, r.monomer);
                    else
                        p.status = lshs_pkg::ST_FULL;
                end
            end
            lshs_pkg::CMD_REMOVE:
            begin
                a = slot_of[r.monomer];
                p.slot = lshs_pkg::SLOT_W'(a);
                if (!used[a])
                    p.status = lshs_pkg::ST_EMPTY;
                else
                begin
                    used[a] = 0;
                    // re-home the rest of the occupied run
                    for (int n = 1; n <= lshs_pkg::TABLE_SIZE; n++)
                    begin
                        i = (a + n) % lshs_pkg::TABLE_SIZE;
                        if (!used[i])
                            break;
                        used[i] = 0;
                        if (probe(keys[i], t) == 0)
                            place(t, keys[i], owners[i]);
                    end
                end
            end
            default:
                for (int n = 0; n < lshs_pkg::TABLE_SIZE; n++)
                    used[n] = 0;
        endcase
        pending_rsp.push_back(p);
    endfunction

    function void check_result(lshs_pkg::rsp_t got);
        lshs_pkg::rsp_t want;
        if (pending_rsp.size() == 0)
        begin
            orphans++;
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %p", got);
            return;
        end
        want = pending_rsp.pop_front();
        if (got.hit !== want.hit || got.owner !== want.owner ||
            got.slot !== want.slot || got.status !== want.status)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected %p actual %p", want, got);
        end
    endfunction
endclass

module tb_lattice_site_hash_set;
    import lshs_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  done;
    rsp_t  rsp;
    logic  cfg_we;
    logic  [CFG_IDX_W-1:0] cfg_index;
    logic  [COORD_W-1:0]   cfg_data;

    site_set_scoreboard board;
    int    idle_cycles;
    bit    timed_out;
    // keys currently believed stored, per owner, for well-formed sequences
    bit [KEY_W-1:0] live_key [MAX_OWNERS];
    int    live_owner[$];

    lattice_site_hash_set i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // results cannot be held off, so they are sampled on every edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(rsp);
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("Verification failed");
            $finish;
        end
    end

    // at least one edge so start is never driven twice in one time step
    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 60);
        repeat (n + 1) @(posedge clk);
    endtask

    // one command transfer; start stays high until busy is low at an edge
    task automatic send_command(cmd_e_t c, bit [15:0] x, bit [15:0] y, bit [15:0] z,
                                bit [OWNER_W-1:0] m);
        req_t r;
        r.command = c;
        r.coord_x = x;
        r.coord_y = y;
        r.coord_z = z;
        r.monomer = m;
        start <= 1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_command(r);
        start <= 0;
        sender_gap();
    endtask

    // wait until every result has come, plus slack for a trailing busy phase
    task automatic drain();
        while (board.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (TABLE_SIZE + 40) @(posedge clk);
    endtask

    task automatic write_coefs(bit [15:0] cx, bit [15:0] cy, bit [15:0] cz);
        bit [15:0] v[3];
        v = '{cx, cy, cz};
        for (int i = 0; i < 3; i++)
        begin
            cfg_we    <= 1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= v[i];
            @(posedge clk);
            board.set_coef(i, v[i]);
        end
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // random coordinate, often small to crowd clusters
    function automatic bit [15:0] rand_coord();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(0, 40)) - 20);
    endfunction

    // random insert, lookup, clear, or remove of an owner with a recorded slot
    task automatic random_command();
        int          pick;
        int          idx;
        int unsigned m;
        bit [15:0]   x;
        bit [15:0]   y;
        bit [15:0]   z;
        pick = $urandom_range(0, 99);
        x = rand_coord();
        y = rand_coord();
        z = rand_coord();
        if (pick < 45)
        begin
            m = $urandom_range(0, MAX_OWNERS - 1);
            send_command(CMD_INSERT, x, y, z, OWNER_W'(m));
            // an owner with no recorded slot must never be removed
            if (board.recorded[m])
                live_owner.push_back(m);
        end
        else if (pick < 70 && live_owner.size() != 0)
        begin
            // only owners that have a recorded slot may be removed
            idx = $urandom_range(0, live_owner.size() - 1);
            m = live_owner[idx];
            live_owner.delete(idx);
            send_command(CMD_REMOVE, x, y, z, OWNER_W'(m));
        end
        else if (pick < 98)
        begin
            if (live_owner.size() != 0 && $urandom_range(0, 1))
            begin
                m = live_owner[$urandom_range(0, live_owner.size() - 1)];
                if (board.used[board.slot_of[m]])
                begin
                    x = board.keys[board.slot_of[m]][15:0];
                    y = board.keys[board.slot_of[m]][31:16];
                    z = board.keys[board.slot_of[m]][47:32];
                end
            end
            send_command($urandom_range(0, 1) ? CMD_LOOKUP : CMD_INSERT, x, y, z,
                         OWNER_W'($urandom_range(0, MAX_OWNERS - 1)));
        end
        else
            send_command(CMD_CLEAR, x, y, z, OWNER_W'($urandom_range(0, MAX_OWNERS - 1)));
    endtask

    initial
    begin
        board       = new();
        rst_n       = 0;
        start       = 0;
        req         = '0;
        cfg_we      = 0;
        cfg_index   = '0;
        cfg_data    = '0;
        idle_cycles = 0;
        timed_out   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, every command, hit and miss, empty remove
        send_command(CMD_LOOKUP, 16'h7fff, 16'h8000, 16'h0000, 9'd0);
        send_command(CMD_INSERT, 16'h7fff, 16'h8000, 16'h0000, 9'd0);
        send_command(CMD_INSERT, 16'h8000, 16'h8000, 16'h8000, 9'd511);
        send_command(CMD_INSERT, 16'hffff, 16'hffff, 16'hffff, 9'd1);
        send_command(CMD_INSERT, 16'h7fff, 16'h8000, 16'h0000, 9'd7);
        send_command(CMD_LOOKUP, 16'h8000, 16'h8000, 16'h8000, 9'd0);
        send_command(CMD_INSERT, 16'h0001, 16'h0000, 16'hffff, 9'd2);
        send_command(CMD_INSERT, 16'h0000, 16'h0000, 16'h0000, 9'd3);
        send_command(CMD_INSERT, 16'h0002, 16'hffff, 16'h0000, 9'd4);
        send_command(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 9'd2);
        send_command(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 9'd2);
        send_command(CMD_LOOKUP, 16'h0002, 16'hffff, 16'h0000, 9'd0);
        send_command(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 9'd511);
        send_command(CMD_CLEAR,  16'h0000, 16'h0000, 16'h0000, 9'd0);
        send_command(CMD_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 9'd0);
        send_command(CMD_REMOVE, 16'h0000, 16'h0000, 16'h0000, 9'd3);
        drain();

        // random phases over several hash settings, extremes included;
        // the table is cleared per phase so full-table cases stay rare
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_coefs(16'h0001, 16'h0001, 16'h0001);
                1: write_coefs(16'h7fff, 16'h8000, 16'h0000);
                2: write_coefs(16'h8000, 16'h8000, 16'h8000);
                3: write_coefs(16'h0000, 16'h0000, 16'h0000);
                4: write_coefs(16'h0400, 16'h0001, 16'hffff);
                default: write_coefs(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            live_owner.delete();
            send_command(CMD_CLEAR, 16'h0, 16'h0, 16'h0, 9'd0);
            for (int n = 0; n < 255; n++)
                random_command();
            drain();
        end

        if (board.mismatches == 0 && board.pending_rsp.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### sim.f
design/lshs_pkg.sv
design/lshs_ram.sv
design/lshs_hash.sv
design/lattice_site_hash_set.sv
design/lshs_checker.sv
tb/sv/tb_lattice_site_hash_set.sv
